/* rtl/core/hrhp_pkg.sv */
// ---------------------------------------------------------------------------
// hrhp_pkg
// Types, constants and helper functions shared by the response header parser.
// ---------------------------------------------------------------------------
package hrhp_pkg;

   localparam int MidDepth = 2;
   localparam int OutDepth = 2;

   localparam logic [7:0]  MAX_REASON_BYTES = 8'd63;
   localparam logic [7:0]  REASON_START     = 8'd13;
   localparam logic [7:0]  STATUS_POS_SAT   = 8'd255;
   localparam logic [3:0]  KEY_LEN          = 4'd14;
   localparam logic [16:0] COUNT_SAT        = 17'h1FFFF;
   localparam logic [16:0] LENGTH_MAX       = 17'h0FFFF;
   localparam logic [15:0] LIMIT_AT_RESET   = 16'd8192;

   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_ONE   = 8'h31;
   localparam logic [7:0] CH_NUL   = 8'h00;

   localparam logic [3:0] ERR_NONE       = 4'd0;
   localparam logic [3:0] ERR_TOO_LONG   = 4'd1;
   localparam logic [3:0] ERR_NUL        = 4'd2;
   localparam logic [3:0] ERR_NO_TERM    = 4'd3;
   localparam logic [3:0] ERR_STATUS     = 4'd4;
   localparam logic [3:0] ERR_HEADER     = 4'd5;
   localparam logic [3:0] ERR_BAD_LENGTH = 4'd6;
   localparam logic [3:0] ERR_NO_LENGTH  = 4'd7;
   localparam logic [3:0] ERR_MISMATCH   = 4'd8;

   localparam logic [1:0] KIND_NONE   = 2'd0;
   localparam logic [1:0] KIND_REASON = 2'd1;
   localparam logic [1:0] KIND_BODY   = 2'd2;

   localparam logic [1:0] TP_NONE     = 2'd0;
   localparam logic [1:0] TP_CR       = 2'd1;
   localparam logic [1:0] TP_CRLF     = 2'd2;
   localparam logic [1:0] TP_CRLFCR   = 2'd3;

   typedef enum logic [2:0] {
      PH_STATUS = 3'b001,
      PH_HEADER = 3'b010,
      PH_BODY   = 3'b100
   } phase_type;

   typedef enum logic [4:0] {
      LP_START  = 5'b00001,
      LP_NAME   = 5'b00010,
      LP_VALUE  = 5'b00100,
      LP_DIGITS = 5'b01000,
      LP_TRAIL  = 5'b10000
   } lphase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]  byte_kind;
      logic [7:0]  out_byte;
      logic        done_res;
      logic        ok;
      logic [3:0]  error_code;
      logic [9:0]  status_code;
      logic [15:0] hdr_length;
      logic [15:0] body_total;
   } rsp_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
      logic       is_digit;
      logic       is_print;
      logic       is_alnum;
      logic [7:0] lower_byte;
   } cls_type;

   typedef struct packed {
      phase_type   phase;
      logic [7:0]  spos;
      logic [9:0]  saccum;
      lphase_type  lphase;
      logic [3:0]  npos;
      logic        nmatch;
      logic [16:0] laccum;
      logic        lseen;
      logic [1:0]  term;
      logic [16:0] bcount;
      logic [16:0] bodycnt;
      logic [3:0]  ferr;
      logic        lfault;
      logic        lenfault;
      logic        svalid;
      logic [16:0] lvalue;
   } pst_type;

   typedef struct packed {
      pst_type st;
      logic    pass;
   } tk_type;

   function automatic cls_type classify(logic [7:0] c, logic last);
      cls_type r;
      logic    upper;
      logic    lower;
      r.data_byte  = c;
      r.last_byte  = last;
      r.is_digit   = (c >= 8'h30) && (c <= 8'h39);
      r.is_print   = (c >= 8'h20) && (c <= 8'h7E);
      upper        = (c >= 8'h41) && (c <= 8'h5A);
      lower        = (c >= 8'h61) && (c <= 8'h7A);
      r.is_alnum   = r.is_digit || upper || lower;
      r.lower_byte = upper ? (c + 8'd32) : c;
      return r;
   endfunction

   function automatic logic [7:0] version_char(logic [7:0] pos);
      logic [7:0] r;
      case (pos)
         8'd0:    r = 8'h48;
         8'd1:    r = 8'h54;
         8'd2:    r = 8'h54;
         8'd3:    r = 8'h50;
         8'd4:    r = 8'h2F;
         8'd5:    r = 8'h31;
         8'd6:    r = 8'h2E;
         8'd7:    r = 8'h30;
         default: r = 8'h20;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] key_char(logic [3:0] pos);
      logic [7:0] r;
      case (pos)
         4'd0:    r = 8'h63;
         4'd1:    r = 8'h6F;
         4'd2:    r = 8'h6E;
         4'd3:    r = 8'h74;
         4'd4:    r = 8'h65;
         4'd5:    r = 8'h6E;
         4'd6:    r = 8'h74;
         4'd7:    r = 8'h2D;
         4'd8:    r = 8'h6C;
         4'd9:    r = 8'h65;
         4'd10:   r = 8'h6E;
         4'd11:   r = 8'h67;
         4'd12:   r = 8'h74;
         4'd13:   r = 8'h68;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic pst_type clear_line(pst_type s);
      pst_type r;
      r          = s;
      r.lphase   = LP_START;
      r.npos     = 4'd0;
      r.nmatch   = 1'b1;
      r.laccum   = 17'd0;
      r.lfault   = 1'b0;
      r.lenfault = 1'b0;
      return r;
   endfunction

   function automatic pst_type reset_state();
      pst_type r;
      r.phase    = PH_STATUS;
      r.spos     = 8'd0;
      r.saccum   = 10'd0;
      r.lphase   = LP_START;
      r.npos     = 4'd0;
      r.nmatch   = 1'b1;
      r.laccum   = 17'd0;
      r.lseen    = 1'b0;
      r.term     = TP_NONE;
      r.bcount   = 17'd0;
      r.bodycnt  = 17'd0;
      r.ferr     = ERR_NONE;
      r.lfault   = 1'b0;
      r.lenfault = 1'b0;
      r.svalid   = 1'b0;
      r.lvalue   = 17'd0;
      return r;
   endfunction

endpackage

/* rtl/core/http_response_header_parser.sv */
// ---------------------------------------------------------------------------
// http_response_header_parser
// Checks an HTTP/1.x response byte stream and reports the verdict.
// ---------------------------------------------------------------------------
// channel   ports                      moves
// request   push, full, req_data       one response byte with last marker
// result    pop, empty, rsp_data       one result per request byte
// control   valid, ready, csr_data     response_limit register write
//
// one request per cycle sustained while the result side keeps popping; each byte
// passes through the front register, the byte queue and the result queue in turn.
// reset clears the queues and parser state and sets the limit to 8192.
// a stalled result side fills the result queue, then the byte queue, then
// the front register, and only then raises full.
// ---------------------------------------------------------------------------
module http_response_header_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  hrhp_pkg::req_type req_data,
   output logic              full,
   input  logic              pop,
   output hrhp_pkg::rsp_type rsp_data,
   output logic              empty,
   input  logic              valid,
   output logic              ready,
   input  logic [15:0]       csr_data
);

   hrhp_pkg::cls_type fr_item, mid_item;
   hrhp_pkg::rsp_type bk_item;
   logic              fr_valid, mid_full, mid_empty, mid_pop;
   logic              bk_push, out_full;

   assign ready = 1'b1;

   hrhp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .req_data   (req_data),
      .full       (full),
      .item_valid (fr_valid),
      .item_data  (fr_item),
      .item_full  (mid_full)
   );

   hrhp_fifo #(
      .WIDTH ($bits(hrhp_pkg::cls_type)),
      .DEPTH (hrhp_pkg::MidDepth)
   ) u_mid_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (fr_valid),
      .push_data (fr_item),
      .full      (mid_full),
      .pop       (mid_pop),
      .pop_data  (mid_item),
      .empty     (mid_empty)
   );

   hrhp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_empty (mid_empty),
      .item_data  (mid_item),
      .item_pop   (mid_pop),
      .csr_write  (valid),
      .csr_data   (csr_data),
      .rsp_push   (bk_push),
      .rsp_item   (bk_item),
      .rsp_full   (out_full)
   );

   hrhp_fifo #(
      .WIDTH ($bits(hrhp_pkg::rsp_type)),
      .DEPTH (hrhp_pkg::OutDepth)
   ) u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (bk_push),
      .push_data (bk_item),
      .full      (out_full),
      .pop       (pop),
      .pop_data  (rsp_data),
      .empty     (empty)
   );

endmodule

/* rtl/core/hrhp_fifo.sv */
// ---------------------------------------------------------------------------
// hrhp_fifo
// Small register queue with push/full and pop/empty sides.
// ---------------------------------------------------------------------------
module hrhp_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == DEPTH_C);
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/core/hrhp_front.sv */
// ---------------------------------------------------------------------------
// hrhp_front
// Accepts request bytes and registers them with their character classes.
// ---------------------------------------------------------------------------
module hrhp_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  hrhp_pkg::req_type req_data,
   output logic              full,
   output logic              item_valid,
   output hrhp_pkg::cls_type item_data,
   input  logic              item_full
);

   logic              valid_ff, valid_in;
   hrhp_pkg::cls_type item_ff, item_in;
   logic              accept;

   assign full       = valid_ff && item_full;
   assign accept     = push && !full;
   assign item_valid = valid_ff;
   assign item_data  = item_ff;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (accept) begin
         valid_in = 1'b1;
         item_in  = hrhp_pkg::classify(req_data.data_byte, req_data.last_byte);
      end else if (valid_ff && !item_full) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

endmodule

/* rtl/core/hrhp_back.sv */
// ---------------------------------------------------------------------------
// hrhp_back
// Parser state: status line, header lines, body count and final verdict.
// ---------------------------------------------------------------------------
module hrhp_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              item_empty,
   input  hrhp_pkg::cls_type item_data,
   output logic              item_pop,
   input  logic              csr_write,
   input  logic [15:0]       csr_data,
   output logic              rsp_push,
   output hrhp_pkg::rsp_type rsp_item,
   input  logic              rsp_full
);

   hrhp_pkg::pst_type st_ff, st_in;
   logic [15:0]       limit_ff, limit_in;

   function automatic hrhp_pkg::pst_type note_error(hrhp_pkg::pst_type s,
                                                    logic [3:0] code);
      hrhp_pkg::pst_type r;
      r = s;
      if (r.ferr == hrhp_pkg::ERR_NONE) begin
         r.ferr = code;
      end
      return r;
   endfunction

   function automatic hrhp_pkg::tk_type line_take(hrhp_pkg::pst_type s,
                                                  hrhp_pkg::cls_type c,
                                                  logic [15:0] lim);
      hrhp_pkg::tk_type r;
      logic             good;
      logic [7:0]       rel;
      logic [13:0]      sacc;
      logic [19:0]      prod;
      logic [19:0]      sum;
      r.st   = s;
      r.pass = 1'b0;
      good   = 1'b0;
      rel    = s.spos - hrhp_pkg::REASON_START;
      sacc   = ({4'b0, s.saccum} << 3) + ({4'b0, s.saccum} << 1)
             + {10'b0, c.data_byte[3:0]};
      prod   = ({3'b0, s.laccum} << 3) + ({3'b0, s.laccum} << 1);
      sum    = prod + {16'b0, c.data_byte[3:0]};
      if (s.phase == hrhp_pkg::PH_STATUS) begin
         if (s.spos < 8'd9) begin
            if (s.spos == 8'd7) begin
               good = (c.data_byte == hrhp_pkg::CH_ZERO) ||
                      (c.data_byte == hrhp_pkg::CH_ONE);
            end else begin
               good = (c.data_byte == hrhp_pkg::version_char(s.spos));
            end
         end else if (s.spos < 8'd12) begin
            good = c.is_digit;
            if (good) begin
               r.st.saccum = sacc[9:0];
            end
         end else if (s.spos == 8'd12) begin
            good = (c.data_byte == hrhp_pkg::CH_SPACE);
         end else begin
            good = c.is_print && (rel < hrhp_pkg::MAX_REASON_BYTES);
         end
         if (!good) begin
            r.st.lfault = 1'b1;
         end
         if (s.spos < hrhp_pkg::STATUS_POS_SAT) begin
            r.st.spos = s.spos + 8'd1;
         end
         r.pass = (s.spos >= hrhp_pkg::REASON_START) && !r.st.lfault;
      end else if (s.lphase == hrhp_pkg::LP_START || s.lphase == hrhp_pkg::LP_NAME) begin
         if (c.data_byte == hrhp_pkg::CH_COLON) begin
            if (s.lphase == hrhp_pkg::LP_START) begin
               r.st.lfault = 1'b1;
            end
            if (s.npos != hrhp_pkg::KEY_LEN) begin
               r.st.nmatch = 1'b0;
            end
            r.st.lphase = hrhp_pkg::LP_VALUE;
         end else begin
            if (!c.is_alnum && c.data_byte != hrhp_pkg::CH_DASH) begin
               r.st.lfault = 1'b1;
            end
            if (s.nmatch && s.npos < hrhp_pkg::KEY_LEN &&
                c.lower_byte == hrhp_pkg::key_char(s.npos)) begin
               r.st.npos = s.npos + 4'd1;
            end else begin
               r.st.nmatch = 1'b0;
            end
            r.st.lphase = hrhp_pkg::LP_NAME;
         end
      end else begin
         if (c.data_byte != hrhp_pkg::CH_TAB && !c.is_print) begin
            r.st.lfault = 1'b1;
         end
         if (c.data_byte == hrhp_pkg::CH_SPACE || c.data_byte == hrhp_pkg::CH_TAB) begin
            if (s.lphase == hrhp_pkg::LP_DIGITS) begin
               r.st.lphase = hrhp_pkg::LP_TRAIL;
            end
         end else if (c.is_digit) begin
            if (s.lphase == hrhp_pkg::LP_TRAIL) begin
               r.st.lenfault = 1'b1;
            end else begin
               if (prod > {4'b0, lim}) begin
                  r.st.lenfault = 1'b1;
               end else begin
                  r.st.laccum = sum[16:0];
                  if (sum > {4'b0, lim}) begin
                     r.st.lenfault = 1'b1;
                  end
               end
               r.st.lphase = hrhp_pkg::LP_DIGITS;
            end
         end else begin
            r.st.lenfault = 1'b1;
         end
      end
      return r;
   endfunction

   function automatic hrhp_pkg::pst_type line_close(hrhp_pkg::pst_type s);
      hrhp_pkg::pst_type r;
      r = s;
      if (s.phase == hrhp_pkg::PH_STATUS) begin
         if (s.lfault || s.spos < (hrhp_pkg::REASON_START + 8'd1)) begin
            r = note_error(r, hrhp_pkg::ERR_STATUS);
         end else begin
            r.svalid = 1'b1;
         end
         r.phase = hrhp_pkg::PH_HEADER;
      end else if (s.lphase == hrhp_pkg::LP_START || s.lphase == hrhp_pkg::LP_NAME ||
                   s.lfault) begin
         r = note_error(r, hrhp_pkg::ERR_HEADER);
      end else if (s.nmatch) begin
         if (s.lseen || s.lenfault || s.lphase == hrhp_pkg::LP_VALUE) begin
            r = note_error(r, hrhp_pkg::ERR_BAD_LENGTH);
         end else begin
            r.lseen  = 1'b1;
            r.lvalue = s.laccum;
         end
      end
      return hrhp_pkg::clear_line(r);
   endfunction

   hrhp_pkg::pst_type nx;
   hrhp_pkg::tk_type  tk;
   hrhp_pkg::cls_type cr_cls;
   hrhp_pkg::rsp_type res;
   logic              pending;
   logic [3:0]        err;

   assign item_pop = !item_empty && !rsp_full;
   assign rsp_push = item_pop;
   assign rsp_item = res;
   assign limit_in = csr_write ? csr_data : limit_ff;

   always_comb begin
      nx      = st_ff;
      tk      = '0;
      cr_cls  = hrhp_pkg::classify(hrhp_pkg::CH_CR, 1'b0);
      res     = '0;
      err     = hrhp_pkg::ERR_NONE;
      pending = (st_ff.term == hrhp_pkg::TP_CR) || (st_ff.term == hrhp_pkg::TP_CRLFCR);
      if (nx.bcount < hrhp_pkg::COUNT_SAT) begin
         nx.bcount = nx.bcount + 17'd1;
      end
      if (item_data.data_byte == hrhp_pkg::CH_NUL) begin
         nx.ferr = hrhp_pkg::ERR_NUL;
      end
      if (st_ff.phase == hrhp_pkg::PH_BODY) begin
         if (nx.bodycnt < hrhp_pkg::COUNT_SAT) begin
            nx.bodycnt = nx.bodycnt + 17'd1;
         end
         res.byte_kind = hrhp_pkg::KIND_BODY;
         res.out_byte  = item_data.data_byte;
      end else if (item_data.data_byte == hrhp_pkg::CH_LF && pending) begin
         if (st_ff.term == hrhp_pkg::TP_CRLFCR) begin
            nx.phase = hrhp_pkg::PH_BODY;
            nx       = hrhp_pkg::clear_line(nx);
            nx.term  = hrhp_pkg::TP_NONE;
         end else begin
            nx      = line_close(nx);
            nx.term = hrhp_pkg::TP_CRLF;
         end
      end else begin
         if (pending) begin
            tk = line_take(nx, cr_cls, limit_ff);
            nx = tk.st;
         end
         if (item_data.data_byte == hrhp_pkg::CH_CR) begin
            nx.term = (st_ff.term == hrhp_pkg::TP_CRLF) ? hrhp_pkg::TP_CRLFCR
                                                        : hrhp_pkg::TP_CR;
         end else begin
            nx.term = hrhp_pkg::TP_NONE;
            tk      = line_take(nx, item_data, limit_ff);
            nx      = tk.st;
            if (tk.pass) begin
               res.byte_kind = hrhp_pkg::KIND_REASON;
               res.out_byte  = item_data.data_byte;
            end
         end
      end
      res.done_res = item_data.last_byte;
      if (item_data.last_byte) begin
         if (nx.bcount > {1'b0, limit_ff}) begin
            err = hrhp_pkg::ERR_TOO_LONG;
         end else if (nx.ferr == hrhp_pkg::ERR_NUL) begin
            err = hrhp_pkg::ERR_NUL;
         end else if (nx.phase != hrhp_pkg::PH_BODY) begin
            err = hrhp_pkg::ERR_NO_TERM;
         end else if (nx.ferr != hrhp_pkg::ERR_NONE) begin
            err = nx.ferr;
         end else if (!nx.lseen) begin
            err = hrhp_pkg::ERR_NO_LENGTH;
         end else if (nx.lvalue != nx.bodycnt) begin
            err = hrhp_pkg::ERR_MISMATCH;
         end
         res.ok          = (err == hrhp_pkg::ERR_NONE);
         res.error_code  = err;
         res.status_code = nx.svalid ? nx.saccum : 10'd0;
         res.hdr_length  = nx.lseen ?
                           ((nx.lvalue > hrhp_pkg::LENGTH_MAX) ? 16'hFFFF
                                                               : nx.lvalue[15:0])
                           : 16'd0;
         res.body_total  = (nx.bodycnt > hrhp_pkg::LENGTH_MAX) ? 16'hFFFF
                                                               : nx.bodycnt[15:0];
         nx = hrhp_pkg::reset_state();
      end
      st_in = item_pop ? nx : st_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= hrhp_pkg::reset_state();
         limit_ff <= hrhp_pkg::LIMIT_AT_RESET;
      end else begin
         st_ff    <= st_in;
         limit_ff <= limit_in;
      end
   end

   // response ends leave the parser ready for a new status line
   a_restart: assert property (@(posedge clock) disable iff (reset)
      item_pop && item_data.last_byte
      |=> st_ff.phase == hrhp_pkg::PH_STATUS && st_ff.bcount == 17'd0)
      else $error("parser not restarted after last byte");

   a_body_term: assert property (@(posedge clock) disable iff (reset)
      st_ff.phase == hrhp_pkg::PH_BODY |-> st_ff.term == hrhp_pkg::TP_NONE)
      else $error("terminator progress left in body");

   a_body_count: assert property (@(posedge clock) disable iff (reset)
      st_ff.bodycnt <= st_ff.bcount)
      else $error("body count exceeds byte count");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_full && !item_empty)
      else $error("result pushed without room or request");

endmodule

/* bench/testbench.sv */
// ---------------------------------------------------------------------------
// testbench
// Drives HTTP response byte streams into the response header parser under
// several limit settings and idle patterns, predicts every result and checks
// each one as it is popped.
// ---------------------------------------------------------------------------
class verdict_board;
   int unsigned limit;
   int unsigned phase, spos, saccum, lphase, npos, nmatch, laccum, lseen;
   int unsigned term, bcount, bodycnt, ferr, lfault, lenfault, svalid, lvalue;
   hrhp_pkg::rsp_type pending[$];
   int errors;

   function new();
      limit = hrhp_pkg::LIMIT_AT_RESET;
      errors = 0;
      clear_all();
   endfunction

   function void clear_line_state();
      lphase = 0; npos = 0; nmatch = 1; laccum = 0; lfault = 0; lenfault = 0;
   endfunction

   function void clear_all();
      phase = 0; spos = 0; saccum = 0; lseen = 0; term = 0; bcount = 0;
      bodycnt = 0; ferr = 0; svalid = 0; lvalue = 0;
      clear_line_state();
   endfunction

   function void flag(int unsigned code);
      if (ferr == 0) ferr = code;
   endfunction

   function bit is_print(int unsigned c);
      return c >= 8'h20 && c <= 8'h7e;
   endfunction

   function bit is_dig(int unsigned c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function bit status_byte(int unsigned c);
      int unsigned p;
      bit good;
      byte unsigned ver[9];
      p = spos;
      ver = '{"H", "T", "T", "P", "/", "1", ".", "0", " "};
      if (p < 9) good = (p == 7) ? (c == "0" || c == "1") : (c == ver[p]);
      else if (p < 12) begin
         good = is_dig(c);
         if (good) saccum = saccum * 10 + (c - 8'h30);
      end else if (p == 12) good = (c == hrhp_pkg::CH_SPACE);
      else good = is_print(c) &&
                  (p - hrhp_pkg::REASON_START) < hrhp_pkg::MAX_REASON_BYTES;
      if (!good) lfault = 1;
      if (spos < 255) spos++;
      return p >= hrhp_pkg::REASON_START && lfault == 0;
   endfunction

   function void header_byte(int unsigned c);
      int unsigned lc;
      bit alnum;
      byte unsigned key[14];
      key = '{"c", "o", "n", "t", "e", "n", "t", "-", "l", "e", "n", "g", "t", "h"};
      if (lphase < 2) begin
         if (c == hrhp_pkg::CH_COLON) begin
            if (lphase == 0) lfault = 1;
            if (npos != hrhp_pkg::KEY_LEN) nmatch = 0;
            lphase = 2;
         end else begin
            lc = (c >= 8'h41 && c <= 8'h5a) ? c + 32 : c;
            alnum = is_dig(c) || (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
            if (!alnum && c != hrhp_pkg::CH_DASH) lfault = 1;
            if (nmatch != 0 && npos < hrhp_pkg::KEY_LEN && lc == key[npos]) npos++;
            else nmatch = 0;
            lphase = 1;
         end
         return;
      end
      if (c != hrhp_pkg::CH_TAB && !is_print(c)) lfault = 1;
      if (c == hrhp_pkg::CH_SPACE || c == hrhp_pkg::CH_TAB) begin
         if (lphase == 3) lphase = 4;
      end else if (is_dig(c)) begin
         if (lphase == 4) lenfault = 1;
         else begin
            if (laccum > limit / 10) lenfault = 1;
            else begin
               laccum = laccum * 10 + (c - 8'h30);
               if (laccum > limit) lenfault = 1;
            end
            lphase = 3;
         end
      end else lenfault = 1;
   endfunction

   function bit line_byte(int unsigned c);
      if (phase == 0) return status_byte(c);
      header_byte(c);
      return 0;
   endfunction

   function void end_of_line();
      if (phase == 0) begin
         if (lfault != 0 || spos < hrhp_pkg::REASON_START + 1) flag(hrhp_pkg::ERR_STATUS);
         else svalid = 1;
         phase = 1;
      end else if (lphase < 2 || lfault != 0) flag(hrhp_pkg::ERR_HEADER);
      else if (nmatch != 0) begin
         if (lseen != 0 || lenfault != 0 || lphase == 2) flag(hrhp_pkg::ERR_BAD_LENGTH);
         else begin
            lseen = 1;
            lvalue = laccum;
         end
      end
      clear_line_state();
   endfunction

   function void note_request(hrhp_pkg::req_type rq);
      hrhp_pkg::rsp_type r;
      int unsigned b;
      int unsigned e;
      bit pend;
      b = rq.data_byte;
      r = '0;
      if (bcount < hrhp_pkg::COUNT_SAT) bcount++;
      if (b == 0) ferr = hrhp_pkg::ERR_NUL;
      if (phase == 2) begin
         if (bodycnt < hrhp_pkg::COUNT_SAT) bodycnt++;
         r.byte_kind = hrhp_pkg::KIND_BODY;
         r.out_byte = b;
      end else begin
         pend = (term == hrhp_pkg::TP_CR || term == hrhp_pkg::TP_CRLFCR);
         if (b == hrhp_pkg::CH_LF && pend) begin
            if (term == hrhp_pkg::TP_CRLFCR) begin
               phase = 2;
               clear_line_state();
               term = hrhp_pkg::TP_NONE;
            end else begin
               end_of_line();
               term = hrhp_pkg::TP_CRLF;
            end
         end else begin
            if (pend) void'(line_byte(hrhp_pkg::CH_CR));
            if (b == hrhp_pkg::CH_CR)
               term = (term == hrhp_pkg::TP_CRLF) ? hrhp_pkg::TP_CRLFCR : hrhp_pkg::TP_CR;
            else begin
               term = hrhp_pkg::TP_NONE;
               if (line_byte(b)) begin
                  r.byte_kind = hrhp_pkg::KIND_REASON;
                  r.out_byte = b;
               end
            end
         end
      end
      r.done_res = rq.last_byte;
      if (rq.last_byte) begin
         e = hrhp_pkg::ERR_NONE;
         if (bcount > limit) e = hrhp_pkg::ERR_TOO_LONG;
         else if (ferr == hrhp_pkg::ERR_NUL) e = hrhp_pkg::ERR_NUL;
         else if (phase != 2) e = hrhp_pkg::ERR_NO_TERM;
         else if (ferr != 0) e = ferr;
         else if (lseen == 0) e = hrhp_pkg::ERR_NO_LENGTH;
         else if (lvalue != bodycnt) e = hrhp_pkg::ERR_MISMATCH;
         r.ok = (e == hrhp_pkg::ERR_NONE);
         r.error_code = e;
         r.status_code = svalid ? saccum : 0;
         r.hdr_length = lseen ?
                        ((lvalue > hrhp_pkg::LENGTH_MAX) ? hrhp_pkg::LENGTH_MAX : lvalue) : 0;
         r.body_total = (bodycnt > hrhp_pkg::LENGTH_MAX) ? hrhp_pkg::LENGTH_MAX : bodycnt;
         clear_all();
      end
      pending.push_back(r);
   endfunction

   function void check_result(hrhp_pkg::rsp_type got);
      hrhp_pkg::rsp_type w;
      if (pending.size() == 0) begin
         $error("unexpected result %h", got);
         errors++;
         return;
      end
      w = pending.pop_front();
      if (got.byte_kind != w.byte_kind) begin
         $error("byte_kind exp %0d got %0d", w.byte_kind, got.byte_kind); errors++;
      end
      if (got.out_byte != w.out_byte) begin
         $error("out_byte exp %0d got %0d", w.out_byte, got.out_byte); errors++;
      end
      if (got.done_res != w.done_res) begin
         $error("done_res exp %0d got %0d", w.done_res, got.done_res); errors++;
      end
      if (got.ok != w.ok) begin
         $error("ok exp %0d got %0d", w.ok, got.ok); errors++;
      end
      if (got.error_code != w.error_code) begin
         $error("error_code exp %0d got %0d", w.error_code, got.error_code); errors++;
      end
      if (got.status_code != w.status_code) begin
         $error("status_code exp %0d got %0d", w.status_code, got.status_code); errors++;
      end
      if (got.hdr_length != w.hdr_length) begin
         $error("hdr_length exp %0d got %0d", w.hdr_length, got.hdr_length);
         errors++;
      end
      if (got.body_total != w.body_total) begin
         $error("body_total exp %0d got %0d", w.body_total, got.body_total); errors++;
      end
   endfunction
endclass

module testbench;
   logic clock = 0;
   logic reset = 1;
   logic push = 0;
   hrhp_pkg::req_type req_data = '0;
   logic full;
   logic pop = 0;
   hrhp_pkg::rsp_type rsp_data;
   logic empty;
   logic valid = 0;
   logic ready;
   logic [15:0] csr_data = '0;

   verdict_board board = new();
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   bit hold_off = 0;
   int idle_cycles = 0;
   byte unsigned stream[$];

   http_response_header_parser uut (
      .clock(clock), .reset(reset), .push(push), .req_data(req_data), .full(full),
      .pop(pop), .rsp_data(rsp_data), .empty(empty), .valid(valid), .ready(ready),
      .csr_data(csr_data)
   );

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   always @(posedge clock) begin
      if (!reset && push && !full) board.note_request(req_data);
      if (!reset && pop && !empty) board.check_result(rsp_data);
      if ((push && !full) || (pop && !empty) || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("Some tests failed");
         $finish;
      end
      pop <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic send_byte(byte unsigned b, bit last);
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 0;
         @(posedge clock);
      end
      push <= 1;
      req_data <= '{data_byte: b, last_byte: last};
      @(posedge clock);
      while (full) @(posedge clock);
   endtask

   task automatic end_send();
      push <= 0;
      @(posedge clock);
   endtask

   task automatic send_stream();
      for (int i = 0; i < stream.size(); i++) send_byte(stream[i], i == stream.size() - 1);
      stream.delete();
      end_send();
   endtask

   task automatic add_text(string s);
      for (int i = 0; i < s.len(); i++) stream.push_back(s[i]);
   endtask

   task automatic drain();
      while (board.pending.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_limit(logic [15:0] v);
      drain();
      valid <= 1;
      csr_data <= v;
      @(posedge clock);
      while (!ready) @(posedge clock);
      valid <= 0;
      board.limit = v;
      @(posedge clock);
   endtask

   // mostly well-formed response with random content and optional damage
   task automatic build_response(bit damage);
      int blen;
      int n;
      string s;
      blen = $urandom_range(0, 6);
      add_text($urandom_range(1) ? "HTTP/1.1 " : "HTTP/1.0 ");
      add_text($sformatf("%03d ", $urandom_range(999)));
      n = $urandom_range(1, 8);
      if ($urandom_range(15) == 0) n = $urandom_range(60, 66);
      repeat (n) stream.push_back($urandom_range(8'h20, 8'h7e));
      add_text("\r\n");
      if ($urandom_range(3) == 0) add_text("X-a-9:\t v v \r\n");
      s = $urandom_range(1) ? "Content-Length" : "content-LENGTH";
      if ($urandom_range(7) != 0) add_text($sformatf("%s: %0d \r\n", s, blen));
      if ($urandom_range(9) == 0) add_text($sformatf("%s:%0d\r\n", s, blen));
      add_text("\r\n");
      repeat (blen) stream.push_back($urandom_range(255));
      if (damage) begin
         repeat ($urandom_range(1, 3))
            stream[$urandom_range(stream.size() - 1)] = $urandom_range(255);
      end
   endtask

   task automatic directed();
      add_text("HTTP/1.1 200 OK\r\nContent-Length: 3\r\n\r\nabc"); send_stream();
      add_text("HTTP/1.0 999 ~\r\ncontent-length:0\r\n\r\n"); send_stream();
      add_text("HTTP/1.1 404 x\r\nX-Y: a\r\nContent-Length: 2 \r\n\r\n");
      stream.push_back(8'h00);
      stream.push_back(8'hff);
      send_stream();
      add_text("HTTP/1.2 200 OK\r\nContent-Length: 0\r\n\r\n"); send_stream();
      add_text("HTTP/1.1 200 OK\r\nBad Name: 1\r\nContent-Length: 0\r\n\r\n"); send_stream();
      add_text("HTTP/1.1 200 OK\r\nContent-Length: 1 2\r\n\r\n"); send_stream();
      add_text("HTTP/1.1 200 OK\r\nContent-Length:\r\n\r\n"); send_stream();
      add_text("HTTP/1.1 200 OK\r\nContent-Length: 0\r\nContent-Length: 0\r\n\r\n");
      send_stream();
      add_text("HTTP/1.1 200 OK\r\nA: b\r\n\r\n"); send_stream();
      add_text("HTTP/1.1 200 OK\r\nContent-Length: 5\r\n\r\nab"); send_stream();
      add_text("HTTP/1.1 200 O\rK\r\nContent-Length: 0\n\r\n\r\n"); send_stream();
      add_text("HTTP/1.1 200 OK\r\nContent-Length: 99999\r\n\r\n"); send_stream();
      add_text("HTTP/1.1 200 OK\r\nContent-Length: 0\r\n"); send_stream();
      add_text("HTTP/1.1 20"); stream.push_back(0); send_stream();
      stream.push_back(8'hff); send_stream();
   endtask

   task automatic random_phase(int count);
      while (count > 0) begin
         if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 12)) stream.push_back($urandom_range(255));
         end else build_response($urandom_range(3) == 0);
         count -= stream.size();
         send_stream();
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      directed();
      random_phase(20);
      write_limit(16'd65535);
      send_idle_pct = 51;
      random_phase(25);
      write_limit(16'd0);
      stream.push_back(8'h41); send_stream();
      random_phase(10);
      write_limit(16'd1);
      stream.push_back(8'h41); send_stream();
      recv_stall_pct = 51;
      send_idle_pct = 0;
      random_phase(15);
      write_limit(16'd40);
      random_phase(20);
      write_limit(16'd8192);
      send_idle_pct = 26;
      recv_stall_pct = 26;
      random_phase(25);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      fork
         begin
            hold_off = 1;
            repeat (60) @(posedge clock);
            hold_off = 0;
         end
         random_phase(30);
      join
      drain();
      repeat (20) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end
endmodule

/* http_response_header_parser.f */
rtl/core/hrhp_pkg.sv
rtl/core/hrhp_fifo.sv
rtl/core/hrhp_front.sv
rtl/core/hrhp_back.sv
rtl/core/http_response_header_parser.sv
bench/testbench.sv
